/* rtl/html_tag_strip_entity_decode_unit_macros.svh */
// Assertion macros used by the checker file of the HTML strip/decode unit.
// No dependencies; included by bare file name.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_UNIT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define HTD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent assertion that is also checked during reset.
`define HTD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/htd_pkg.sv */
// Package for the HTML tag strip / entity decode unit: constants, entity
// tables and the result bundle passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package htd_pkg;

	localparam int NUM_ENT     = 6;
	localparam int TAIL_LEN    = 5;
	localparam int HOLD_DEPTH  = 4;
	localparam int HOLD_CNT_W  = 3;
	localparam int MAX_RES     = 6;
	localparam int RES_CNT_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	typedef logic [7:0] byte_t;

	// Register word indexes on the configuration port
	localparam logic [CFG_ADDR_W-3:0] REG_SKIP_FIRST_PARA = 1'b0;

	localparam byte_t CH_LT  = 8'h3C;
	localparam byte_t CH_GT  = 8'h3E;
	localparam byte_t CH_AMP = 8'h26;
	localparam byte_t CH_P   = 8'h70;
	localparam byte_t CH_B   = 8'h62;
	localparam byte_t CH_R   = 8'h72;
	localparam byte_t CH_NL  = 8'h0A;

	// Entity names after the '&', zero padded
	localparam byte_t ENT_TAIL [NUM_ENT][TAIL_LEN] = '{
		'{"a", "m", "p", ";", 8'h00},
		'{"l", "t", ";", 8'h00, 8'h00},
		'{"g", "t", ";", 8'h00, 8'h00},
		'{"q", "u", "o", "t", ";"},
		'{"a", "p", "o", "s", ";"},
		'{"#", "3", "9", ";", 8'h00}
	};
	localparam logic [HOLD_CNT_W-1:0] ENT_LEN [NUM_ENT] = '{
		3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd4
	};
	localparam byte_t ENT_VAL [NUM_ENT] = '{
		8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27
	};

	// All results caused by one input beat
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] data;
		logic [RES_CNT_W-1:0]    cnt;    // number of results, 1..MAX_RES
		logic                    empty;  // single empty end marker
		logic                    last;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* rtl/htd_ifs.sv */
// Valid/ready channel interfaces of the HTML strip/decode unit:
// raw text bytes in, plain text results out. No dependencies.
`timescale 1ns / 1ps

interface htd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface htd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output out_byte, output has_byte, output last,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input last,
		output ready);
endinterface

/* rtl/html_tag_strip_entity_decode_unit.sv */
// Top level of the HTML tag strip / entity decode unit.
// Depends on htd_pkg, htd_ifs, htd_front, htd_queue and htd_back.
//
// Usage: raw HTML bytes enter on the html channel (text_byte, end_of_text),
// one byte per beat. Plain text leaves on the plain channel, one result per
// beat (out_byte, has_byte, last). Tags are dropped, "<br" and "<p" tags
// become newlines and the common entities are decoded; end_of_text flushes
// held bytes and the final result of the text carries last. A text that
// yields nothing still gives one result with has_byte low and last high.
// The first result of a beat is registered in the bundle queue and then in
// the output stage. Throughput: one input beat per cycle while the queue
// is not full and each beat yields at most one result; a beat that yields
// k results (k up to 6) holds the output until all k are taken. A four-deep
// bundle queue between the front end and the output stage lets input
// continue while the receiver stalls; html.ready drops only when it is full.
// Reset clears the tag and entity flags and counters, the queue and the
// output; the skip_first_paragraph register (APB word 0, bit 0) resets to zero.
// The user must write it only while the unit is idle; the block does not enforce it.
`timescale 1ns / 1ps

module html_tag_strip_entity_decode_unit import htd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	htd_in_if.sink                html,
	htd_out_if.source             plain,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic        skip_q;
	logic        q_push;
	logic        q_pop;
	bundle_t     q_in;
	bundle_t     q_out;
	queue_stat_t q_stat;
	logic        cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_SKIP_FIRST_PARA);
	assign prdata  = cfg_hit ? CFG_DATA_W'(skip_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skip_q <= 1'b0;
		else if (psel && penable && pwrite && pready && cfg_hit)
			skip_q <= pwdata[0];
	end

	htd_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.skip_first_paragraph (skip_q),
		.html                 (html),
		.q_stat               (q_stat),
		.q_push               (q_push),
		.q_data               (q_in)
	);

	htd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.stat      (q_stat)
	);

	htd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_out),
		.pop    (q_pop),
		.plain  (plain)
	);

endmodule

/* rtl/htd_front.sv */
// Front end: accepts text beats, tracks tag and entity state and turns each
// beat into a bundle of results. Depends on htd_pkg and htd_ifs.
`timescale 1ns / 1ps

module htd_front import htd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          skip_first_paragraph,
	htd_in_if.sink        html,
	input  queue_stat_t   q_stat,
	output logic          q_push,
	output bundle_t       q_data
);

	typedef enum logic [1:0] {PFX_NONE, PFX_LT, PFX_LTB} pfx_t;

	pfx_t                  prefix_q, prefix_n;
	logic                  inside_q, inside_n;
	logic                  para_q, para_n;
	logic                  ent_act_q, ent_act_n;
	logic [HOLD_CNT_W-1:0] ent_cnt_q, ent_cnt_n;
	logic [NUM_ENT-1:0]    ent_mask_q, ent_mask_n;
	byte_t                 held_q [HOLD_DEPTH];
	byte_t                 held_n [HOLD_DEPTH];

	logic                  accept;
	byte_t                 b;
	logic                  eot;
	logic [NUM_ENT-1:0]    hit, done, cont;
	byte_t                 done_val;
	logic                  run_plain;
	logic [RES_CNT_W-1:0]  n;
	byte_t                 res [MAX_RES];

	assign html.ready = !q_stat.full;
	assign accept     = html.valid && !q_stat.full;
	assign b          = html.text_byte;
	assign eot        = html.end_of_text;

	// Each entity still in the race checks its next name character
	always_comb begin
		done_val = '0;
		for (int k = 0; k < NUM_ENT; k++) begin
			hit[k]  = ent_mask_q[k] && (ENT_TAIL[k][ent_cnt_q] == b);
			done[k] = hit[k] && ((ent_cnt_q + 3'd1) == ENT_LEN[k]);
			if (done[k])
				done_val = done_val | ENT_VAL[k];
		end
		cont = hit & ~done;
	end

	always_comb begin
		n          = '0;
		for (int i = 0; i < MAX_RES; i++)
			res[i] = '0;
		prefix_n   = prefix_q;
		inside_n   = inside_q;
		para_n     = para_q;
		ent_act_n  = ent_act_q;
		ent_cnt_n  = ent_cnt_q;
		ent_mask_n = ent_mask_q;
		held_n     = held_q;
		run_plain  = 1'b1;

		if (ent_act_q) begin
			run_plain = 1'b0;
			if (|done) begin
				res[n]    = done_val;
				n         = n + 3'd1;
				ent_act_n = 1'b0;
				ent_cnt_n = '0;
			end else if ((|cont) && (ent_cnt_q != 3'(HOLD_DEPTH))) begin
				held_n[ent_cnt_q[1:0]] = b;
				ent_cnt_n  = ent_cnt_q + 3'd1;
				ent_mask_n = cont;
			end else begin
				// unmatched ampersand: flush literally, then treat b as plain
				res[n] = CH_AMP;
				n      = n + 3'd1;
				for (int i = 0; i < HOLD_DEPTH; i++) begin
					if (3'(i) < ent_cnt_q) begin
						res[n] = held_q[i];
						n      = n + 3'd1;
					end
				end
				ent_act_n = 1'b0;
				ent_cnt_n = '0;
				run_plain = 1'b1;
			end
		end

		if (run_plain) begin
			priority if (b == CH_LT) begin
				inside_n = 1'b1;
				prefix_n = PFX_LT;
			end else if (inside_q) begin
				priority if (prefix_q == PFX_LT && b == CH_P) begin
					if (!(skip_first_paragraph && !para_q)) begin
						res[n] = CH_NL;
						n      = n + 3'd1;
						res[n] = CH_NL;
						n      = n + 3'd1;
					end
					para_n   = 1'b1;
					prefix_n = PFX_NONE;
				end else if (prefix_q == PFX_LT && b == CH_B) begin
					prefix_n = PFX_LTB;
				end else if (prefix_q == PFX_LTB && b == CH_R) begin
					res[n]   = CH_NL;
					n        = n + 3'd1;
					prefix_n = PFX_NONE;
				end else begin
					prefix_n = PFX_NONE;
				end
				if (b == CH_GT)
					inside_n = 1'b0;
			end else if (b == CH_AMP) begin
				ent_act_n  = 1'b1;
				ent_cnt_n  = '0;
				ent_mask_n = '1;
			end else begin
				res[n] = b;
				n      = n + 3'd1;
			end
		end

		if (eot) begin
			if (ent_act_n) begin
				res[n] = CH_AMP;
				n      = n + 3'd1;
				for (int i = 0; i < HOLD_DEPTH; i++) begin
					if (3'(i) < ent_cnt_n) begin
						res[n] = held_n[i];
						n      = n + 3'd1;
					end
				end
			end
			prefix_n  = PFX_NONE;
			inside_n  = 1'b0;
			para_n    = 1'b0;
			ent_act_n = 1'b0;
			ent_cnt_n = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_RES; i++)
			q_data.data[i] = res[i];
		q_data.empty = (n == '0);
		q_data.cnt   = (n == '0) ? 3'd1 : n;
		q_data.last  = eot;
	end

	assign q_push = accept && ((n != '0) || eot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= PFX_NONE;
			inside_q   <= 1'b0;
			para_q     <= 1'b0;
			ent_act_q  <= 1'b0;
			ent_cnt_q  <= '0;
			ent_mask_q <= '0;
		end else if (accept) begin
			prefix_q   <= prefix_n;
			inside_q   <= inside_n;
			para_q     <= para_n;
			ent_act_q  <= ent_act_n;
			ent_cnt_q  <= ent_cnt_n;
			ent_mask_q <= ent_mask_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_n;
	end

endmodule

/* rtl/htd_queue.sv */
// Short bundle queue between front and back end so each side stalls alone.
// Depends on htd_pkg.
`timescale 1ns / 1ps

module htd_queue import htd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     push_data,
	input  logic        pop,
	output bundle_t     pop_data,
	output queue_stat_t stat
);

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/htd_back.sv */
// Back end: takes one bundle at a time from the queue and hands its results
// out one beat each. Depends on htd_pkg and htd_ifs.
`timescale 1ns / 1ps

module htd_back import htd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t q_stat,
	input  bundle_t     q_data,
	output logic        pop,
	htd_out_if.source   plain
);

	bundle_t              cur_q;
	logic                 cur_vld_q;
	logic [RES_CNT_W-1:0] idx_q;
	logic                 final_beat;
	logic                 take;

	assign final_beat = ((idx_q + 3'd1) == cur_q.cnt);
	assign take       = cur_vld_q && plain.ready;
	assign pop        = !q_stat.empty && (!cur_vld_q || (take && final_beat));

	assign plain.valid    = cur_vld_q;
	assign plain.out_byte = cur_q.data[idx_q];
	assign plain.has_byte = !cur_q.empty;
	assign plain.last     = cur_q.last && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (pop) begin
			cur_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (take) begin
			if (final_beat)
				cur_vld_q <= 1'b0;
			else
				idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_data;
	end

endmodule

/* rtl/htd_checker.sv */
// Port-level checker for the HTML strip/decode unit and its bind.
// Depends on html_tag_strip_entity_decode_unit_macros.svh.
`timescale 1ns / 1ps
`include "html_tag_strip_entity_decode_unit_macros.svh"

module htd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_has_byte,
	input logic       out_last
);

	// a stalled result beat must not move
	`HTD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable({out_byte, out_has_byte, out_last}), "stalled result changed")

	// the empty marker only ends a text
	`HTD_ASSERT(a_empty_is_last, clk, arst_n, out_valid && !out_has_byte |-> out_last && (out_byte == 8'h00), "empty result without last")

	// a full queue frees up only after a result beat drains the output
	`HTD_ASSERT(a_ready_after_drain, clk, arst_n, !in_ready |=> !in_ready || $past(out_valid && out_ready), "input ready returned without a result beat")

	// output flops may start unknown; the edge after reset is seen they must be clear
	`HTD_ASSERT_ALWAYS(a_quiet_in_reset, clk, !arst_n |=> !out_valid, "result valid during reset")

endmodule

bind html_tag_strip_entity_decode_unit htd_checker u_htd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (html.ready),
	.out_valid    (plain.valid),
	.out_ready    (plain.ready),
	.out_byte     (plain.out_byte),
	.out_has_byte (plain.has_byte),
	.out_last     (plain.last)
);

/* bench/testbench.sv */
// Self-checking bench for html_tag_strip_entity_decode_unit: directed and random HTML texts in,
// plain text checked beat by beat against an in-bench predictor of the stripper.
// Depends on htd_pkg, htd_ifs and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
	import htd_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam byte_t NEWLINE = 8'h0A;
	localparam logic [CFG_ADDR_W-1:0] SKIP_ADDR = {REG_SKIP_FIRST_PARA, 2'b00};

	typedef struct packed {
		byte_t text_byte;
		logic  end_of_text;
	} html_beat_t;

	typedef struct packed {
		byte_t out_byte;
		logic  has_byte;
		logic  last;
	} plain_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;

	htd_in_if html_ch();
	htd_out_if plain_ch();

	html_tag_strip_entity_decode_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.html(html_ch),
		.plain(plain_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	html_beat_t  pending_beats[$];
	plain_beat_t plain_expected[$];
	byte_t       text_acc[$];
	int          err_cnt = 0;
	int          idle_cycles = 0;
	bit          idle_on = 1'b1;
	bit          in_took = 1'b0;
	int          in_gap = 0;
	int          out_stall = 0;

	// predictor state
	bit          skip_para;
	bit          tag_open;
	logic [1:0]  tag_match;   // 0 none, 1 after '<', 2 after "<b"
	bit          amp_open;
	logic [2:0]  amp_cnt;
	byte_t       amp_held [HOLD_DEPTH];
	bit          para_done;

	function automatic string ent_tail(int k);
		case (k)
			0: return "amp;";
			1: return "lt;";
			2: return "gt;";
			3: return "quot;";
			4: return "apos;";
			default: return "#39;";
		endcase
	endfunction

	function automatic byte_t ent_char(int k);
		case (k)
			0: return "&";
			1: return "<";
			2: return ">";
			3: return "\"";
			default: return "'";
		endcase
	endfunction

	task automatic emit_byte(input byte_t b);
		plain_expected.push_back('{out_byte: b, has_byte: 1'b1, last: 1'b0});
	endtask

	task automatic flush_held();
		emit_byte("&");
		for (int i = 0; i < amp_cnt; i++)
			emit_byte(amp_held[i]);
		amp_open = 1'b0;
		amp_cnt = '0;
	endtask

	task automatic strip_byte(input byte_t b);
		if (b == "<") begin
			tag_open = 1'b1;
			tag_match = 2'd1;
		end else if (tag_open) begin
			if (tag_match == 2'd1 && b == "p") begin
				if (!(skip_para && !para_done)) begin
					emit_byte(NEWLINE);
					emit_byte(NEWLINE);
				end
				para_done = 1'b1;
				tag_match = 2'd0;
			end else if (tag_match == 2'd1 && b == "b") begin
				tag_match = 2'd2;
			end else if (tag_match == 2'd2 && b == "r") begin
				emit_byte(NEWLINE);
				tag_match = 2'd0;
			end else begin
				tag_match = 2'd0;
			end
			if (b == ">")
				tag_open = 1'b0;
		end else if (b == "&") begin
			amp_open = 1'b1;
			amp_cnt = '0;
		end else begin
			emit_byte(b);
		end
	endtask

	task automatic clear_text();
		tag_open = 1'b0;
		tag_match = 2'd0;
		amp_open = 1'b0;
		amp_cnt = '0;
		para_done = 1'b0;
	endtask

	// Expected plain beats for one accepted html beat
	task automatic decode_beat(input html_beat_t beat);
		int    base;
		int    c;
		int    hit;
		bit    alive;
		bit    ok;
		string tail;
		byte_t b;
		base = plain_expected.size();
		b = beat.text_byte;
		if (amp_open) begin
			c = amp_cnt;
			alive = 1'b0;
			hit = -1;
			for (int k = 0; k < NUM_ENT; k++) begin
				tail = ent_tail(k);
				if (c >= tail.len())
					continue;
				ok = 1'b1;
				for (int i = 0; i < c; i++)
					if (amp_held[i] != tail[i])
						ok = 1'b0;
				if (!ok || tail[c] != b)
					continue;
				if (c + 1 == tail.len()) begin
					hit = k;
					break;
				end
				alive = 1'b1;
			end
			if (hit >= 0) begin
				emit_byte(ent_char(hit));
				amp_open = 1'b0;
				amp_cnt = '0;
			end else if (alive && c < HOLD_DEPTH) begin
				amp_held[c] = b;
				amp_cnt = 3'(c + 1);
			end else begin
				flush_held();
				strip_byte(b);
			end
		end else begin
			strip_byte(b);
		end
		if (beat.end_of_text) begin
			if (amp_open)
				flush_held();
			if (plain_expected.size() == base)
				plain_expected.push_back('{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1});
			else
				plain_expected[plain_expected.size() - 1].last = 1'b1;
			clear_text();
		end
	endtask

	// Driver: inputs change on the falling edge
	always @(negedge clk) begin
		html_beat_t nxt;
		if (arst_n) begin
			if (!html_ch.valid || in_took) begin
				if (in_gap > 0) begin
					in_gap--;
					html_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					nxt = pending_beats.pop_front();
					html_ch.valid <= 1'b1;
					html_ch.text_byte <= nxt.text_byte;
					html_ch.end_of_text <= nxt.end_of_text;
					if (idle_on && $urandom_range(0, 7) == 0)
						in_gap = $urandom_range(1, 19);
				end else begin
					html_ch.valid <= 1'b0;
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				plain_ch.ready <= 1'b0;
			end else begin
				plain_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					out_stall = $urandom_range(1, 19);
			end
		end
	end

	// Monitor: both channels sampled on the rising edge, plus the watchdog
	always @(posedge clk) begin
		plain_beat_t exp_beat;
		bit in_fire;
		bit out_fire;
		if (arst_n) begin
			in_fire = html_ch.valid && html_ch.ready;
			out_fire = plain_ch.valid && plain_ch.ready;
			in_took <= in_fire;
			if (in_fire)
				decode_beat('{text_byte: html_ch.text_byte, end_of_text: html_ch.end_of_text});
			if (out_fire) begin
				if (plain_expected.size() == 0) begin
					$error("plain beat with nothing expected: out_byte %h has_byte %b last %b",
						plain_ch.out_byte, plain_ch.has_byte, plain_ch.last);
					err_cnt++;
				end else begin
					exp_beat = plain_expected.pop_front();
					if (plain_ch.out_byte !== exp_beat.out_byte) begin
						$error("out_byte: expected %h, got %h", exp_beat.out_byte, plain_ch.out_byte);
						err_cnt++;
					end
					if (plain_ch.has_byte !== exp_beat.has_byte) begin
						$error("has_byte: expected %b, got %b", exp_beat.has_byte, plain_ch.has_byte);
						err_cnt++;
					end
					if (plain_ch.last !== exp_beat.last) begin
						$error("last: expected %b, got %b", exp_beat.last, plain_ch.last);
						err_cnt++;
					end
				end
			end
			if (in_fire || out_fire)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
		input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_skip_para(input bit v);
		logic [CFG_DATA_W-1:0] rd;
		apb_access(1'b1, SKIP_ADDR, CFG_DATA_W'(v), rd);
		skip_para = v;
		apb_access(1'b0, SKIP_ADDR, '0, rd);
		if (rd !== CFG_DATA_W'(v)) begin
			$error("skip_first_paragraph: expected %h, got %h", CFG_DATA_W'(v), rd);
			err_cnt++;
		end
	endtask

	// Let everything in flight come out, including beats that yield nothing;
	// checked just after the falling edge so the driver's updates have landed
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pending_beats.size() != 0 || html_ch.valid || plain_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_acc.push_back(s[i]);
	endtask

	// Move the collected text to the driver queue, end mark on the final byte
	task automatic commit_text();
		for (int i = 0; i < text_acc.size(); i++)
			pending_beats.push_back('{text_byte: text_acc[i],
				end_of_text: (i == text_acc.size() - 1)});
		text_acc.delete();
	endtask

	task automatic add_fragment();
		string tail;
		int    k;
		case ($urandom_range(0, 13))
			0, 1, 2: repeat ($urandom_range(1, 4)) text_acc.push_back(byte_t'($urandom_range(32, 126)));
			3: text_acc.push_back(byte_t'($urandom_range(0, 255)));
			4: begin
				case ($urandom_range(0, 9))
					0: push_str("<br>");
					1: push_str("<p>");
					2: push_str("<pre>");
					3: push_str("</p>");
					4: push_str("<b>");
					5: push_str("<brx a>");
					6: push_str("<p class=x>");
					7: push_str("<<p>");
					8: push_str("<b<br>");
					default: push_str("<>");
				endcase
			end
			5: begin
				text_acc.push_back("<");
				repeat ($urandom_range(0, 5)) begin
					k = $urandom_range(0, 255);
					text_acc.push_back((k == ">") ? byte_t'("r") : byte_t'(k));
				end
				if ($urandom_range(0, 5) != 0)
					text_acc.push_back(">");
			end
			6, 7, 8: begin
				text_acc.push_back("&");
				push_str(ent_tail($urandom_range(0, NUM_ENT - 1)));
			end
			9, 10: begin
				// entity name cut short, left to whatever follows
				tail = ent_tail($urandom_range(0, NUM_ENT - 1));
				text_acc.push_back("&");
				push_str(tail.substr(0, $urandom_range(0, tail.len() - 2)));
			end
			11: begin
				case ($urandom_range(0, 6))
					0: push_str("&&lt;");
					1: push_str("&<p>");
					2: push_str("&;");
					3: push_str("&ampx");
					4: push_str("&#3");
					5: push_str("&apos");
					default: push_str("&quo&gt;");
				endcase
			end
			12: text_acc.push_back(">");
			default: text_acc.push_back(($urandom_range(0, 1) != 0) ? NEWLINE : byte_t'(" "));
		endcase
	endtask

	task automatic queue_random_texts(input int n_beats);
		int added;
		added = 0;
		while (added < n_beats) begin
			repeat ($urandom_range(1, 8)) add_fragment();
			added += text_acc.size();
			commit_text();
		end
	endtask

	initial begin
		html_ch.valid = 1'b0;
		html_ch.text_byte = '0;
		html_ch.end_of_text = 1'b0;
		plain_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		skip_para = 1'b0;
		clear_text();
		for (int i = 0; i < HOLD_DEPTH; i++)
			amp_held[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_skip_para(1'b0);

		// directed: byte extremes, lone '>', paragraph, unmatched '&' into a tag,
		// numeric entity, entity cut by end of text, empty result, '<' inside a tag
		text_acc.push_back(8'h00);
		text_acc.push_back(8'hFF);
		push_str("><p>");
		commit_text();
		push_str("&q<br");
		commit_text();
		push_str("&#39;");
		commit_text();
		push_str("&am");
		commit_text();
		push_str("<");
		commit_text();
		push_str("</<p");
		commit_text();
		wait_drained();

		queue_random_texts(120);
		wait_drained();
		set_skip_para(1'b1);
		queue_random_texts(120);
		wait_drained();
		set_skip_para(1'b0);
		queue_random_texts(100);
		wait_drained();
		set_skip_para(1'b1);
		idle_on = 1'b0;
		in_gap = 0;
		out_stall = 0;
		queue_random_texts(100);
		wait_drained();

		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
